>>> rtl/xfbc_pkg.sv
// ----------------------------------------------------------------------------
// xfbc_pkg: shared definitions for the XOR Feistel block cipher
// Field widths, request codes, register indexes and the key address wrap table.
// ----------------------------------------------------------------------------
package xfbc_pkg;

    localparam int KEY_BYTES      = 124;
    localparam int KEY_AW         = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int OFF_W          = 7;
    localparam int BYTE_W         = 8;
    localparam int BLOCK_W        = 64;
    localparam int HALF_W         = 32;
    localparam int REQ_W          = 2;
    localparam int CFG_REGS       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int ROUNDS         = 4;
    localparam int BYTES_PER_WORD = 4;
    localparam int STEP_W         = 5;
    localparam int LAST_STEP      = ROUNDS * BYTES_PER_WORD;

    localparam logic [REQ_W-1:0] REQ_KEY_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCRYPT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DECRYPT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 3'd3;

    typedef logic [KEY_AW-1:0] key_addr_t;
    typedef key_addr_t wrap_tab_t [1 << OFF_W];

    function automatic wrap_tab_t build_wrap_tab();
        wrap_tab_t tab;
        for (int i = 0; i < (1 << OFF_W); i++)
        begin
            tab[i] = key_addr_t'(i % KEY_BYTES);
        end
        return tab;
    endfunction

    localparam wrap_tab_t OFF_WRAP = build_wrap_tab();
    localparam key_addr_t KEY_LAST = key_addr_t'(KEY_BYTES - 1);

endpackage

>>> rtl/xfbc_if.sv
// ----------------------------------------------------------------------------
// xfbc_if: channel interfaces for the XOR Feistel block cipher
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface xfbc_req_if;
    import xfbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [OFF_W-1:0]    key_index;
    logic [BYTE_W-1:0]   key_byte;
    logic [BLOCK_W-1:0]  block_in;

    modport source (output valid, output req_type, output key_index, output key_byte,
                    output block_in, input ready);
    modport sink   (input valid, input req_type, input key_index, input key_byte,
                    input block_in, output ready);
endinterface

interface xfbc_rsp_if;
    import xfbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [BLOCK_W-1:0]  block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

interface xfbc_cfg_if;
    import xfbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [OFF_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/xor_feistel_block_cipher.sv
// ----------------------------------------------------------------------------
// xor_feistel_block_cipher: four-round Feistel cipher on 64-bit blocks
// Key bytes live in a store with one read port; one key byte is fetched per
// cycle and one round is applied every four fetches.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transfer
//  req     | in  | req_type, key_index, key_byte, block_in  | valid & ready
//  rsp     | out | block_out                                | valid & ready
//  cfg     | in  | index, data (round offsets 0..3)         | valid & ready
//
//  A key write leaves req ready.
//  After its transfer a block makes its 16 key byte reads through the key store's
//  one read port, then loads the output register.
//  The result register lets the next request in while a result waits; a block
//  finishing while rsp is stalled holds until the slot frees.
//  Reset clears the key store valid bits, the round offsets and all control.
// ----------------------------------------------------------------------------
module xor_feistel_block_cipher (
    input  logic       clk,
    input  logic       rst_n,
    xfbc_req_if.sink   req,
    xfbc_rsp_if.source rsp,
    xfbc_cfg_if.sink   cfg
);
    import xfbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     decrypt_reg, decrypt_next;
    logic [HALF_W-1:0]        left_reg, left_next;
    logic [HALF_W-1:0]        right_reg, right_next;
    logic [3*BYTE_W-1:0]      kacc_reg, kacc_next;
    key_addr_t                addr_reg, addr_next;
    logic [OFF_W-1:0]         offset_reg [CFG_REGS];
    logic [BYTE_W-1:0]        key_mem [KEY_BYTES];
    logic [KEY_BYTES-1:0]     key_vld_reg;
    logic [BYTE_W-1:0]        rd_data_reg;
    logic                     rd_vld_reg;
    logic [BLOCK_W-1:0]       out_reg;
    logic                     out_valid_reg;

    logic                     req_fire;
    logic                     key_we;
    key_addr_t                key_waddr;
    logic                     cfg_fire;
    logic                     out_load;
    logic [1:0]               round_sel;
    logic [OFF_W-1:0]         round_off;
    key_addr_t                rd_addr;
    logic [BYTE_W-1:0]        key_byte_rd;
    logic [HALF_W-1:0]        round_key;

    assign req.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.block_out = out_reg;

    assign req_fire  = req.valid && req.ready;
    assign key_we    = req_fire && (req.req_type == REQ_KEY_WRITE)
                       && (int'(req.key_index) < KEY_BYTES);
    assign key_waddr = key_addr_t'(req.key_index);
    assign cfg_fire  = cfg.valid && cfg.ready;

    assign round_sel = decrypt_reg ? ~step_reg[3:2] : step_reg[3:2];
    assign round_off = offset_reg[round_sel];

    always_comb
    begin
        if (step_reg[1:0] == 2'd0)
        begin
            rd_addr = OFF_WRAP[round_off];
        end
        else if (addr_reg == KEY_LAST)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = addr_reg + key_addr_t'(1);
        end
    end

    assign key_byte_rd = rd_vld_reg ? rd_data_reg : '0;
    assign round_key   = {kacc_reg, key_byte_rd};

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        decrypt_next = decrypt_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        kacc_next    = kacc_reg;
        addr_next    = addr_reg;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && ((req.req_type == REQ_ENCRYPT)
                                 || (req.req_type == REQ_DECRYPT)))
                begin
                    left_next    = req.block_in[BLOCK_W-1:HALF_W];
                    right_next   = req.block_in[HALF_W-1:0];
                    decrypt_next = (req.req_type == REQ_DECRYPT);
                    step_next    = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                addr_next = rd_addr;
                if (step_reg != '0)
                begin
                    kacc_next = {kacc_reg[2*BYTE_W-1:0], key_byte_rd};
                    if (step_reg[1:0] == 2'd0)
                    begin
                        left_next  = right_reg;
                        right_next = left_reg ^ right_reg ^ round_key;
                    end
                end
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            decrypt_reg   <= 1'b0;
            key_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CFG_REGS; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            decrypt_reg <= decrypt_next;
            rd_vld_reg  <= key_vld_reg[rd_addr];
            if (key_we)
            begin
                key_vld_reg[key_waddr] <= 1'b1;
            end
            if (cfg_fire && (cfg.index <= CFG_LAST_INDEX))
            begin
                offset_reg[cfg.index[1:0]] <= cfg.data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= req.key_byte;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        kacc_reg  <= kacc_next;
        addr_reg  <= addr_next;
        if (out_load)
        begin
            out_reg <= {right_reg, left_reg};
        end
    end

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && ((req.req_type == REQ_ENCRYPT) || (req.req_type == REQ_DECRYPT)))
        |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("block transfer did not start the round sequence");

    a_key_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == REQ_KEY_WRITE))
        |=> (state_reg == ST_IDLE))
        else $error("key write left the idle state");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (step_reg == STEP_W'(LAST_STEP))
        |=> (state_reg == ST_DONE))
        else $error("round sequence overran its last step");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready)
        |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished block not moved to the result register");

endmodule
